/* rtl/apcf_pkg.sv */
// Package for the box collision filter: payload structs, command codes,
// controller/datapath handshake structs and parameter defaults. No dependencies.
package apcf_pkg;

  localparam int unsigned DEF_MAX_BOXES  = 16;
  localparam int unsigned DEF_GROUP_BITS = 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SCAN  = 1'b1;

  typedef struct packed {
    logic               command;
    logic [3:0]         slot;
    logic signed [15:0] left_x;
    logic signed [15:0] top_y;
    logic [11:0]        box_width;
    logic [11:0]        box_height;
    logic [15:0]        category_bits;
    logic [15:0]        interest_mask;
    logic               alive;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] subject;
    logic [3:0] other;
    logic       last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic write_box;   // store the input box (if its slot is in the table)
    logic start_scan;  // latch the row and read its entry
    logic load_row;    // capture the row entry, point the walker past the row
    logic step_j;      // advance the walker
    logic read_j;      // read the entry under the walker
    logic emit_fwd;    // notice (row, j)
    logic emit_rev;    // notice (j, row)
    logic emit_done;   // scan done marker
  } apcf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_scan;   // input item is a scan command
    logic row_ok;    // input slot in table and its box live
    logic j_end;     // walker ran past the table
    logic j_live;    // box under the walker is live
    logic a_wants;   // row box interested in the partner
    logic b_wants;   // partner interested in the row box
    logic overlap;   // boxes touch or overlap
    logic out_free;  // output register can take a result this cycle
  } apcf_stat_t;

endpackage

/* rtl/apcf_datapath.sv */
// Datapath of the box collision filter: box table memory, live bits, row
// register, partner walker, overlap/group test and output register. Uses apcf_pkg.
module apcf_datapath #(
  parameter int unsigned MAX_BOXES  = apcf_pkg::DEF_MAX_BOXES,
  parameter int unsigned GROUP_BITS = apcf_pkg::DEF_GROUP_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  apcf_pkg::in_item_t   in_item_i,
  input  apcf_pkg::apcf_cmd_t  cmd_i,
  output apcf_pkg::apcf_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output apcf_pkg::out_item_t  out_item_o
);
  import apcf_pkg::*;

  localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);

  typedef struct packed {
    logic [15:0]           x;
    logic [15:0]           y;
    logic [11:0]           w;
    logic [11:0]           h;
    logic [GROUP_BITS-1:0] cat;
    logic [GROUP_BITS-1:0] msk;
  } entry_t;

  entry_t                mem_q [MAX_BOXES];
  entry_t                rd_q;
  entry_t                row_q;
  entry_t                wr_entry;
  logic [MAX_BOXES-1:0]  live_q;
  logic [IDX_W-1:0]      in_addr;
  logic [IDX_W-1:0]      row_addr_q;
  logic [IDX_W-1:0]      j_addr;
  logic [CNT_W-1:0]      j_q;
  logic [3:0]            slot_q;
  logic [3:0]            j_low;
  logic [31:0]           slot_ext;
  logic [31:0]           j_ext;
  logic [31:0]           cat_ext;
  logic [31:0]           msk_ext;
  logic                  in_slot_ok;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic signed [17:0]    ax_l, ax_r, bx_l, bx_r;
  logic signed [17:0]    ay_t, ay_b, by_t, by_b;

  assign slot_ext   = 32'(in_item_i.slot);
  assign in_addr    = slot_ext[IDX_W-1:0];
  assign in_slot_ok = slot_ext < 32'(MAX_BOXES);
  assign cat_ext    = 32'(in_item_i.category_bits);
  assign msk_ext    = 32'(in_item_i.interest_mask);
  assign j_addr     = j_q[IDX_W-1:0];
  assign j_ext      = 32'(j_q);
  assign j_low      = j_ext[3:0];

  always_comb begin
    wr_entry.x   = in_item_i.left_x;
    wr_entry.y   = in_item_i.top_y;
    wr_entry.w   = in_item_i.box_width;
    wr_entry.h   = in_item_i.box_height;
    wr_entry.cat = cat_ext[GROUP_BITS-1:0];
    wr_entry.msk = msk_ext[GROUP_BITS-1:0];
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_box && in_slot_ok) begin
      mem_q[in_addr] <= wr_entry;
    end
  end

  assign rd_en   = cmd_i.start_scan | cmd_i.read_j;
  assign rd_addr = cmd_i.start_scan ? in_addr : j_addr;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (cmd_i.write_box && in_slot_ok) begin
      live_q[in_addr] <= in_item_i.alive;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_scan) begin
      slot_q     <= in_item_i.slot;
      row_addr_q <= in_addr;
    end
    if (cmd_i.load_row) begin
      row_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else if (cmd_i.load_row) begin
      j_q <= CNT_W'(row_addr_q) + CNT_W'(1);
    end else if (cmd_i.step_j) begin
      j_q <= j_q + CNT_W'(1);
    end
  end

  // inclusive overlap: each box's near edge lies at or before the other's far edge
  assign ax_l = {{2{row_q.x[15]}}, row_q.x};
  assign ax_r = ax_l + {6'b0, row_q.w};
  assign bx_l = {{2{rd_q.x[15]}}, rd_q.x};
  assign bx_r = bx_l + {6'b0, rd_q.w};
  assign ay_t = {{2{row_q.y[15]}}, row_q.y};
  assign ay_b = ay_t + {6'b0, row_q.h};
  assign by_t = {{2{rd_q.y[15]}}, rd_q.y};
  assign by_b = by_t + {6'b0, rd_q.h};

  always_comb begin
    stat_o.in_scan  = in_item_i.command == CMD_SCAN;
    stat_o.row_ok   = in_slot_ok && live_q[in_addr];
    stat_o.j_end    = j_q == CNT_W'(MAX_BOXES);
    stat_o.j_live   = live_q[j_addr];
    stat_o.a_wants  = |(row_q.msk & rd_q.cat);
    stat_o.b_wants  = |(rd_q.msk & row_q.cat);
    stat_o.overlap  = (ax_l <= bx_r) && (bx_l <= ax_r) &&
                      (ay_t <= by_b) && (by_t <= ay_b);
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_fwd || cmd_i.emit_rev || cmd_i.emit_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_fwd) begin
      out_q <= '{hit: 1'b1, subject: slot_q, other: j_low, last: 1'b0};
    end else if (cmd_i.emit_rev) begin
      out_q <= '{hit: 1'b1, subject: j_low, other: slot_q, last: 1'b0};
    end else if (cmd_i.emit_done) begin
      out_q <= '{hit: 1'b0, subject: slot_q, other: 4'd0, last: 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/apcf_ctrl.sv */
// Controller of the box collision filter: one-hot state machine that sequences
// writes, the row load, the partner walk and result transfers. Uses apcf_pkg.
module apcf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  apcf_pkg::apcf_stat_t stat_i,
  output apcf_pkg::apcf_cmd_t  cmd_o
);
  import apcf_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_LOAD_ROW = 7'b0000010,
    ST_SEEK     = 7'b0000100,
    ST_TEST     = 7'b0001000,
    ST_EMIT_FWD = 7'b0010000,
    ST_EMIT_REV = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (stat_i.in_scan) begin
            cmd_o.start_scan = 1'b1;
            state_d = stat_i.row_ok ? ST_LOAD_ROW : ST_DONE;
          end else begin
            cmd_o.write_box = 1'b1;
          end
        end
      end
      ST_LOAD_ROW: begin
        cmd_o.load_row = 1'b1;
        state_d = ST_SEEK;
      end
      ST_SEEK: begin
        if (stat_i.j_end) begin
          state_d = ST_DONE;
        end else if (!stat_i.j_live) begin
          cmd_o.step_j = 1'b1;
        end else begin
          cmd_o.read_j = 1'b1;
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (stat_i.overlap && stat_i.a_wants) begin
          state_d = ST_EMIT_FWD;
        end else if (stat_i.overlap && stat_i.b_wants) begin
          state_d = ST_EMIT_REV;
        end else begin
          cmd_o.step_j = 1'b1;
          state_d = ST_SEEK;
        end
      end
      ST_EMIT_FWD: begin
        if (stat_i.out_free) begin
          cmd_o.emit_fwd = 1'b1;
          if (stat_i.b_wants) begin
            state_d = ST_EMIT_REV;
          end else begin
            cmd_o.step_j = 1'b1;
            state_d = ST_SEEK;
          end
        end
      end
      ST_EMIT_REV: begin
        if (stat_i.out_free) begin
          cmd_o.emit_rev = 1'b1;
          cmd_o.step_j   = 1'b1;
          state_d = ST_SEEK;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/aabb_pair_collision_filter_top.sv */
// Box collision filter, top level: joins the controller and the datapath.
// Depends on apcf_pkg, apcf_ctrl and apcf_datapath.
//
// Keeps a table of MAX_BOXES boxes. A write command stores one box. A scan of
// row i walks slots i+1..MAX_BOXES-1 through the single read port of the box
// table: it starts and loads the row, skips each dead slot, reads and tests
// each live slot and sends its notices, finds the end of the table and sends
// the done marker; a stall on the output side holds the scan. A scan of a dead
// or out-of-table row sends only the done marker. Items are taken one at a
// time; the next is accepted once the current scan's done marker has gone into
// the output register.
module aabb_pair_collision_filter_top #(
  parameter int unsigned MAX_BOXES  = apcf_pkg::DEF_MAX_BOXES,
  parameter int unsigned GROUP_BITS = apcf_pkg::DEF_GROUP_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  apcf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output apcf_pkg::out_item_t out_item_o
);
  import apcf_pkg::*;

  apcf_cmd_t  cmd;
  apcf_stat_t stat;

  apcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  apcf_datapath #(
    .MAX_BOXES  (MAX_BOXES),
    .GROUP_BITS (GROUP_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
